// ===== sv/crc32_msb_first_byte_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// crc32_msb_first_byte_engine_core_assert.svh
// Assertion macros for the byte-serial CRC-32 engine.
// ----------------------------------------------------------------------------
`ifndef CRC32_MSB_FIRST_BYTE_ENGINE_CORE_ASSERT_SVH
`define CRC32_MSB_FIRST_BYTE_ENGINE_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== sv/crc32mf_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32mf_pkg
// Constants and the table-entry function of the MSB-first CRC-32 engine.
// ----------------------------------------------------------------------------
package crc32mf_pkg;

    localparam int unsigned CRC_W  = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 3;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_TOP  = 32'h8000_0000;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] CNT_FULL = 3'd4;

    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Divide one byte placed at the top of the register through eight steps.
    function automatic crc_t table_entry(input byte_t idx);
        crc_t acc;
        acc = {idx, 24'h00_0000};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((acc & CRC_TOP) != '0) begin
                acc = {acc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[CRC_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

// ===== sv/crc32_msb_first_byte_engine_core.sv =====
// Path: an item goes through the input register, then the result register, to m_tdata.
// Throughput: one item per cycle unless the result register is full and stalled; the
// update into the remainder register is a lane XOR (first four bytes) or one table fold.
// Reset: aresetn, synchronous, active low; clears both channels' valid flags and
// sets the remainder to all ones and the byte count to zero.
// ----------------------------------------------------------------------------
// crc32_msb_first_byte_engine_core
// Byte-serial non-reflected CRC-32 (poly 0x04C11DB7), direct-table form.
// ----------------------------------------------------------------------------
module crc32_msb_first_byte_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    input  logic        s_tuser,    // [0] empty_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [31:0] checksum
);

    // Input register
    logic                 in_valid_reg, in_valid_next;
    crc32mf_pkg::byte_t   in_byte_reg;
    logic                 in_last_reg;
    logic                 in_empty_reg;

    // State
    crc32mf_pkg::crc_t    remainder_reg, remainder_next;
    crc32mf_pkg::cnt_t    bytes_seen_reg, bytes_seen_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    crc32mf_pkg::crc_t    out_data_reg, out_data_next;

    logic                 pipe_en;
    logic                 fire;
    logic                 done;
    crc32mf_pkg::crc_t    rem_upd;
    crc32mf_pkg::cnt_t    cnt_upd;

    // Advance whenever the result register is empty or being drained.
    assign pipe_en  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || pipe_en;
    assign fire     = in_valid_reg && pipe_en;
    assign done     = in_empty_reg || in_last_reg;

    always_comb begin
        rem_upd = remainder_reg;
        cnt_upd = bytes_seen_reg;
        if (bytes_seen_reg < crc32mf_pkg::CNT_FULL) begin
            cnt_upd = bytes_seen_reg + 3'd1;
            unique case (bytes_seen_reg[1:0])
                2'd0: rem_upd = remainder_reg ^ {in_byte_reg, 24'h00_0000};
                2'd1: rem_upd = remainder_reg ^ {8'h00, in_byte_reg, 16'h0000};
                2'd2: rem_upd = remainder_reg ^ {16'h0000, in_byte_reg, 8'h00};
                default: rem_upd = remainder_reg ^ {24'h00_0000, in_byte_reg};
            endcase
        end else begin
            rem_upd = {remainder_reg[23:0], in_byte_reg}
                      ^ crc32mf_pkg::table_entry(remainder_reg[31:24]);
        end
    end

    always_comb begin
        in_valid_next   = in_valid_reg;
        remainder_next  = remainder_reg;
        bytes_seen_next = bytes_seen_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (pipe_en) begin
            out_valid_next = fire && done;
            out_data_next  = in_empty_reg ? '0 : ~rem_upd;
        end
        if (fire) begin
            if (done) begin
                remainder_next  = crc32mf_pkg::CRC_INIT;
                bytes_seen_next = '0;
            end else begin
                remainder_next  = rem_upd;
                bytes_seen_next = cnt_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            remainder_reg  <= crc32mf_pkg::CRC_INIT;
            bytes_seen_reg <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            remainder_reg  <= remainder_next;
            bytes_seen_reg <= bytes_seen_next;
        end
    end

    // Payload: capture on accept, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`include "crc32_msb_first_byte_engine_core_assert.svh"

    `CRC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid right after reset")
    `CRC_ASSERT(a_cnt_sat, bytes_seen_reg <= crc32mf_pkg::CNT_FULL, "byte count past saturation")
    `CRC_ASSERT(a_empty_zero, fire && in_empty_reg |=> out_valid_reg && out_data_reg == '0, "empty message must give zero")
    `CRC_ASSERT(a_state_reset, fire && done |=> bytes_seen_reg == '0 && remainder_reg == crc32mf_pkg::CRC_INIT, "state not reset at message end")
    `CRC_ASSERT(a_mid_silent, fire && !done && m_tready |=> !out_valid_reg, "middle byte produced a result")

endmodule

// ===== tb/sv/crc32_msb_first_byte_engine_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc32_msb_first_byte_engine_core_tb
// Self-checking bench for the byte-serial MSB-first CRC-32 engine. A clocked
// driver streams message bytes from a queue. A bit-serial model of the CRC
// predicts each checksum at the moment its item is accepted. A clocked monitor
// compares every checksum that leaves the block, in order. Directed messages
// come first: empty, one- to five-byte messages, and an abandoned one. Random
// traffic follows, in three phases with different back-pressure.
// ----------------------------------------------------------------------------
module crc32_msb_first_byte_engine_core_tb;

    typedef struct packed {
        crc32mf_pkg::byte_t data;
        logic               last;
        logic               empty;
    } msg_item_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    crc32mf_pkg::byte_t  s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    crc32mf_pkg::crc_t   m_tdata;

    msg_item_t         msg_item_q[$];
    crc32mf_pkg::crc_t checksum_q[$];

    // Running state of the checksum model.
    crc32mf_pkg::crc_t crc_rem   = crc32mf_pkg::CRC_INIT;
    crc32mf_pkg::cnt_t crc_count = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int n_fail      = 0;

    crc32_msb_first_byte_engine_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Division of the byte shifted out at the top, done one bit at a time.
    function automatic crc32mf_pkg::crc_t crc_fold(input crc32mf_pkg::byte_t top);
        crc32mf_pkg::crc_t acc;
        int                k;
        acc = '0;
        for (k = crc32mf_pkg::BYTE_W - 1; k >= 0; k--) begin
            if (acc[crc32mf_pkg::CRC_W-1] ^ top[k]) begin
                acc = {acc[crc32mf_pkg::CRC_W-2:0], 1'b0} ^ crc32mf_pkg::CRC_POLY;
            end else begin
                acc = {acc[crc32mf_pkg::CRC_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

    task automatic crc_absorb(input crc32mf_pkg::byte_t data, input logic last,
                              input logic empty);
        if (empty) begin
            checksum_q.push_back('0);
            crc_rem   = crc32mf_pkg::CRC_INIT;
            crc_count = '0;
        end else begin
            if (crc_count < crc32mf_pkg::CNT_FULL) begin
                // fill the register from the top, one byte lane per item
                crc_rem   = crc_rem ^ (crc32mf_pkg::crc_t'(data)
                                       << (8 * (3 - int'(crc_count))));
                crc_count = crc_count + 1'b1;
            end else begin
                crc_rem = {crc_rem[crc32mf_pkg::CRC_W-9:0], data}
                          ^ crc_fold(crc_rem[crc32mf_pkg::CRC_W-1 -: 8]);
            end
            if (last) begin
                checksum_q.push_back(~crc_rem);
                crc_rem   = crc32mf_pkg::CRC_INIT;
                crc_count = '0;
            end
        end
    endtask

    // Driver: predict on acceptance, then present the next item or idle.
    always @(posedge aclk) begin
        msg_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                crc_absorb(s_tdata, s_tlast, s_tuser);
            end
            if (!s_tvalid || s_tready) begin
                if (msg_item_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    it = msg_item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.data;
                    s_tlast  <= it.last;
                    s_tuser  <= it.empty;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: every checksum must match the oldest prediction.
    always @(posedge aclk) begin
        crc32mf_pkg::crc_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (checksum_q.size() == 0) begin
                $error("checksum %h arrived with none expected", m_tdata);
                n_fail++;
            end else begin
                want = checksum_q.pop_front();
                if (m_tdata !== want) begin
                    $error("checksum mismatch: expected %h, actual %h", want, m_tdata);
                    n_fail++;
                end
            end
        end
    end

    task automatic push_item(input crc32mf_pkg::byte_t data, input logic last,
                             input logic empty);
        msg_item_t it;
        it.data  = data;
        it.last  = last;
        it.empty = empty;
        msg_item_q.push_back(it);
    endtask

    task automatic push_bytes(input crc32mf_pkg::byte_t b[$]);
        int k;
        for (k = 0; k < b.size(); k++) begin
            push_item(b[k], k == b.size() - 1, 1'b0);
        end
    endtask

    // Mostly short messages, some long ones, some cut off by an empty marker.
    task automatic add_random_traffic(input int n_items);
        int queued;
        int sel;
        int len;
        int k;
        queued = 0;
        while (queued < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                push_item(crc32mf_pkg::byte_t'($urandom), 1'($urandom), 1'b1);
                queued++;
            end else begin
                len = (sel < 10) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                for (k = 0; k < len; k++) begin
                    if (k == len - 1 && sel >= 10 && sel < 15) begin
                        push_item(crc32mf_pkg::byte_t'($urandom), 1'($urandom), 1'b1);
                    end else begin
                        push_item(crc32mf_pkg::byte_t'($urandom), k == len - 1, 1'b0);
                    end
                end
                queued += len;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (msg_item_q.size() != 0 || s_tvalid || checksum_q.size() != 0);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 23;
        rx_idle_pct = 81;
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_bytes('{8'hA5, 8'h5A});
        push_bytes('{8'h01, 8'h80, 8'h7F});
        push_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        push_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h80});
        // abandon a message part way through
        push_item(8'h12, 1'b0, 1'b0);
        push_item(8'h34, 1'b0, 1'b0);
        push_item(8'h56, 1'b0, 1'b0);
        push_item(8'hAB, 1'b0, 1'b1);
        add_random_traffic(600);
        // hold off the sender until the block has drained
        wait_drained();

        tx_idle_pct = 81;
        rx_idle_pct = 23;
        add_random_traffic(600);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_traffic(600);
        wait_drained();
        repeat (10) @(negedge aclk);

        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/crc32mf_pkg.sv
sv/crc32_msb_first_byte_engine_core.sv
tb/sv/crc32_msb_first_byte_engine_core_tb.sv
